// ===== rtl/autorange_resistance_meter_core_defines.svh =====
// ----------------------------------------------------------------------------
// Autorange resistance meter - assertion macros
// Shared property shorthands for the checker, clocked on clk_i and held off
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef AUTORANGE_RESISTANCE_METER_CORE_DEFINES_SVH
`define AUTORANGE_RESISTANCE_METER_CORE_DEFINES_SVH

// same-cycle implication
`define ARM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("arm check failed");

// next-cycle implication
`define ARM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("arm check failed");

`endif

// ===== rtl/arm_pkg.sv =====
// ----------------------------------------------------------------------------
// Autorange resistance meter - package
// Field widths, thresholds, command and register codes.
// ----------------------------------------------------------------------------
package arm_pkg;

  localparam int unsigned READING_W = 16;
  localparam int unsigned REF_W     = 20;
  localparam int unsigned RANGE_W   = 2;
  localparam int unsigned RES_W     = 30;
  localparam int unsigned PROD_W    = REF_W + READING_W;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [READING_W-1:0] FULL_SCALE  = 16'd65535;
  localparam logic [READING_W-1:0] MIN_DIVISOR = 16'd100;
  localparam logic [READING_W-1:0] LOW_STEP1   = 16'd13000;
  localparam logic [READING_W-1:0] LOW_STEP2   = 16'd1750;
  localparam logic [READING_W-1:0] HIGH_STEP1  = 16'd52500;
  localparam logic [READING_W-1:0] HIGH_STEP2  = 16'd63800;

  typedef enum logic {
    CMD_PROBE = 1'b0,
    CMD_FINAL = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF0        = 3'd0,
    CFG_REF1        = 3'd1,
    CFG_REF2        = 3'd2,
    CFG_REF3        = 3'd3,
    CFG_AUTORANGE   = 3'd4,
    CFG_FIXED_RANGE = 3'd5
  } cfg_idx_e;

endpackage

// ===== rtl/arm_stream_if.sv =====
// ----------------------------------------------------------------------------
// Autorange resistance meter - stream interfaces
// Valid/ready channels for readings in and measurement results out.
// ----------------------------------------------------------------------------
interface arm_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [arm_pkg::READING_W-1:0]  reading;

  modport source (output valid, output command, output reading, input ready);
  modport sink   (input valid, input command, input reading, output ready);
endinterface

interface arm_out_if;
  logic                           valid;
  logic                           ready;
  logic [arm_pkg::RANGE_W-1:0]    range_now;
  logic                           range_changed;
  logic [arm_pkg::RES_W-1:0]      resistance;
  logic                           resistance_valid;

  modport source (output valid, output range_now, output range_changed,
                  output resistance, output resistance_valid, input ready);
  modport sink   (input valid, input range_now, input range_changed,
                  input resistance, input resistance_valid, output ready);
endinterface

// ===== rtl/arm_mul.sv =====
// ----------------------------------------------------------------------------
// Autorange resistance meter - serial multiplier
// Radix-4 shift-add: two multiplier bits per cycle, LSB first.
// ----------------------------------------------------------------------------
module arm_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [arm_pkg::REF_W-1:0]     mcand_i,
  input  logic [arm_pkg::READING_W-1:0] mplier_i,
  output logic                          done_o,
  output logic [arm_pkg::PROD_W-1:0]    prod_o
);

  localparam int unsigned DIGIT_W = 2;
  localparam int unsigned STEPS   = arm_pkg::READING_W / DIGIT_W;
  localparam int unsigned CNT_W   = $clog2(STEPS);
  localparam int unsigned HI_W    = arm_pkg::REF_W + DIGIT_W;

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [arm_pkg::REF_W-1:0]     mcand_q;
  logic [HI_W-1:0]               hi_q;
  logic [arm_pkg::READING_W-1:0] lo_q;
  logic [HI_W-1:0]               part;
  logic [HI_W:0]                 sum;

  assign part = HI_W'(mcand_q) * HI_W'(lo_q[DIGIT_W-1:0]);
  assign sum  = {1'b0, hi_q} + {1'b0, part};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      hi_q    <= '0;
      lo_q    <= mplier_i;
    end else if (busy_q) begin
      // low digit of the partial sum retires into the product's low half
      hi_q <= HI_W'(sum[HI_W:DIGIT_W]);
      lo_q <= {sum[DIGIT_W-1:0], lo_q[arm_pkg::READING_W-1:DIGIT_W]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[arm_pkg::REF_W-1:0], lo_q};

endmodule

// ===== rtl/arm_div.sv =====
// ----------------------------------------------------------------------------
// Autorange resistance meter - serial divider
// Restoring radix-2 divide, one quotient bit per cycle. The top bits of the
// dividend sit below any legal divisor, so only the low quotient bits are run.
// ----------------------------------------------------------------------------
module arm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [arm_pkg::PROD_W-1:0]    dividend_i,
  input  logic [arm_pkg::READING_W-1:0] divisor_i,
  output logic                          done_o,
  output logic [arm_pkg::RES_W-1:0]     quot_o
);

  localparam int unsigned DW    = arm_pkg::READING_W;
  localparam int unsigned QW    = arm_pkg::RES_W;
  localparam int unsigned STEPS = QW;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    dvs_q;
  logic [QW-1:0]    quo_q;
  logic [DW:0]      shifted;
  logic [DW+1:0]    diff;
  logic             fits;

  assign shifted = {rem_q, quo_q[QW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = ~diff[DW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DW'(dividend_i[arm_pkg::PROD_W-1:QW]);
      quo_q <= dividend_i[QW-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
      quo_q <= {quo_q[QW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/autorange_resistance_meter_core.sv =====
// ----------------------------------------------------------------------------
// Autorange resistance meter - core
// Range stepping on probe readings (in autorange mode) and ohms conversion on final readings.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives one result. A probe, or a
// final reading whose divisor 65535-v is below 100, is registered on
// acceptance and moves into the output register once that register is free;
// the next request is taken only after that. A valid final reading runs
// through the radix-4 serial multiplier (reference x reading) and then the
// restoring divider, one quotient bit per cycle, before its result moves
// into the output register. The next request is taken only after that. A
// finished result may wait in the output register while the next request
// is taken; a second finished result holds the input closed until the
// output register drains. Configuration is to be written while idle through
// cfg_we_i/cfg_index_i/cfg_data_i; the core itself does not enforce this.
module autorange_resistance_meter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [arm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [arm_pkg::REF_W-1:0]     cfg_data_i,
  arm_in_if.sink                        in_i,
  arm_out_if.source                     out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_HOLD
  } state_e;

  localparam int unsigned RW = arm_pkg::RANGE_W;

  function automatic logic [RW-1:0] next_range(input logic [RW-1:0] now,
                                               input logic [arm_pkg::READING_W-1:0] v);
    logic [RW:0]   up;
    logic [RW-1:0] stp;
    logic [RW-1:0] r;
    r   = now;
    up  = '0;
    stp = '0;
    if (v < arm_pkg::LOW_STEP1) begin
      up = {1'b0, now} + ((v < arm_pkg::LOW_STEP2) ? (RW+1)'(2) : (RW+1)'(1));
      r  = (up > (RW+1)'(3)) ? RW'(3) : up[RW-1:0];
    end else if (v > arm_pkg::HIGH_STEP1) begin
      stp = (v > arm_pkg::HIGH_STEP2) ? RW'(2) : RW'(1);
      r   = (now < stp) ? '0 : now - stp;
    end
    return r;
  endfunction

  state_e                         state_q;
  logic [arm_pkg::REF_W-1:0]      ref_q [4];
  logic                           autorange_q;
  logic [RW-1:0]                  fixed_range_q;
  logic [RW-1:0]                  cur_range_q;

  logic [RW-1:0]                  res_range_q;
  logic                           res_changed_q;
  logic [arm_pkg::RES_W-1:0]      res_value_q;
  logic                           res_valid_q;
  logic [arm_pkg::READING_W-1:0]  divisor_q;

  logic                           out_valid_q;
  logic [RW-1:0]                  out_range_q;
  logic                           out_changed_q;
  logic [arm_pkg::RES_W-1:0]      out_value_q;
  logic                           out_res_valid_q;

  logic                           accept;
  logic                           is_final;
  logic [RW-1:0]                  range_eff;
  logic [RW-1:0]                  probe_range;
  logic [arm_pkg::READING_W-1:0]  divisor;
  logic                           div_ok;
  logic                           mul_start;
  logic                           mul_done;
  logic [arm_pkg::PROD_W-1:0]     mul_prod;
  logic                           div_start;
  logic                           div_done;
  logic [arm_pkg::RES_W-1:0]      div_quot;
  logic                           out_load;

  assign in_i.ready  = (state_q == S_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign is_final    = (in_i.command == arm_pkg::CMD_FINAL);
  assign range_eff   = autorange_q ? cur_range_q : fixed_range_q;
  assign probe_range = next_range(cur_range_q, in_i.reading);
  assign divisor     = arm_pkg::FULL_SCALE - in_i.reading;
  assign div_ok      = (divisor >= arm_pkg::MIN_DIVISOR);
  assign mul_start   = accept && is_final && div_ok;
  assign div_start   = (state_q == S_MUL) && mul_done;
  assign out_load    = (state_q == S_HOLD) && (!out_valid_q || out_o.ready);

  arm_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (ref_q[range_eff]),
    .mplier_i (in_i.reading),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  arm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_prod),
    .divisor_i  (divisor_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) ref_q[i] <= '0;
      autorange_q   <= 1'b1;
      fixed_range_q <= RW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        arm_pkg::CFG_REF0:        ref_q[0]      <= cfg_data_i;
        arm_pkg::CFG_REF1:        ref_q[1]      <= cfg_data_i;
        arm_pkg::CFG_REF2:        ref_q[2]      <= cfg_data_i;
        arm_pkg::CFG_REF3:        ref_q[3]      <= cfg_data_i;
        arm_pkg::CFG_AUTORANGE:   autorange_q   <= cfg_data_i[0];
        arm_pkg::CFG_FIXED_RANGE: fixed_range_q <= cfg_data_i[RW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, range state and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_range_q <= RW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= mul_start ? S_MUL : S_HOLD;
            if (!is_final && autorange_q) cur_range_q <= probe_range;
          end
        end
        S_MUL: begin
          if (mul_done) state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state_q <= S_HOLD;
        end
        S_HOLD: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (is_final) begin
        res_range_q <= range_eff;
      end else begin
        res_range_q <= autorange_q ? probe_range : fixed_range_q;
      end
      res_changed_q <= !is_final && autorange_q && (probe_range != cur_range_q);
      res_value_q   <= '0;
      res_valid_q   <= 1'b0;
      divisor_q     <= divisor;
    end else if ((state_q == S_DIV) && div_done) begin
      res_value_q <= div_quot;
      res_valid_q <= 1'b1;
    end
    if (out_load) begin
      out_range_q     <= res_range_q;
      out_changed_q   <= res_changed_q;
      out_value_q     <= res_value_q;
      out_res_valid_q <= res_valid_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.range_now        = out_range_q;
  assign out_o.range_changed    = out_changed_q;
  assign out_o.resistance       = out_value_q;
  assign out_o.resistance_valid = out_res_valid_q;

endmodule

// ===== rtl/arm_checker.sv =====
// ----------------------------------------------------------------------------
// Autorange resistance meter - port checker
// Watches the core's channels over time; attached to the core by bind.
// ----------------------------------------------------------------------------
`include "autorange_resistance_meter_core_defines.svh"

module arm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [arm_pkg::RANGE_W-1:0] out_range_i,
  input logic                        out_changed_i,
  input logic [arm_pkg::RES_W-1:0]   out_res_i,
  input logic                        out_res_valid_i
);

  localparam int unsigned PAYLOAD_W = arm_pkg::RANGE_W + arm_pkg::RES_W + 2;

  logic [PAYLOAD_W-1:0] out_payload;

  assign out_payload = {out_range_i, out_changed_i, out_res_i, out_res_valid_i};

  // a stalled result must hold
  `ARM_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_payload))

  // one request at a time: taking one closes the input
  `ARM_ASSERT_NXT(a_one_at_a_time, in_valid_i && in_ready_i, !in_ready_i)

  // a new result only appears once the input has been closed
  `ARM_ASSERT_IMP(a_result_after_busy, $rose(out_valid_i), !$past(in_ready_i))

  // uncomputed results carry zero ohms
  `ARM_ASSERT_IMP(a_invalid_zero, out_valid_i && !out_res_valid_i, out_res_i == '0)

endmodule

bind autorange_resistance_meter_core arm_checker u_arm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_range_i     (out_o.range_now),
  .out_changed_i   (out_o.range_changed),
  .out_res_i       (out_o.resistance),
  .out_res_valid_i (out_o.resistance_valid)
);
